>>> rtl/efb_pkg.sv
// Shared types and constants for the escaped frame builder.
package efb_pkg;

  // Framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] ESC_BYTE  = 8'hFD;

  // Register reset values
  localparam logic [7:0] CMD_RESET = 8'h81;
  localparam logic [7:0] LEN_RESET = 8'd48;

  // Register select (address bit 2)
  localparam logic REG_CMD = 1'b0;
  localparam logic REG_LEN = 1'b1;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Logical byte positions the back end walks through
  typedef enum logic [2:0] {
    SLOT_SYNC,
    SLOT_CMD,
    SLOT_LEN,
    SLOT_DATA,
    SLOT_CSUM
  } slot_e;

  // One classified request: what the back end has to send for it
  typedef struct packed {
    logic       start;  // opens a frame: sync, command and length first
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] data;
    logic       close;  // closes the frame: checksum last
    logic [7:0] csum;
  } job_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic esc_pending;  // second half of an escape pair is due
    logic busy;         // partway through the head job
  } back_status_t;

  // True for bytes that must be escaped on the line
  function automatic logic needs_escape(input logic [7:0] value);
    return (value == SYNC_BYTE) || (value == ESC_BYTE);
  endfunction

endpackage

>>> rtl/escaped_frame_builder_with_checksum_unit.sv
// Top level of the escaped frame builder with sum checksum.
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ------------------------------------
//  payload   in         push_i / full_o      payload_byte_i
//  line      out        pop_i / empty_o      line_byte_o, run_last_o, frame_end_o
//  config    in         APB psel/penable     command_code @0x0, payload_length @0x4
//
// The front end takes one payload byte per cycle while the job queue has room.
// The back end sends one line byte per cycle while its output is empty or popped,
// each of sync, command, length, payload and checksum that the request carries,
// all but sync possibly escaped. A request's first line byte goes through the job
// queue and then the output register. Reset clears frame position, sum, queue and
// output; the registers return to command 0x81 and length 48. A stalled line
// output backs up into the queue and then raises full_o.
module escaped_frame_builder_with_checksum_unit
  import efb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // payload input
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  payload_byte_i,
  // line output
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  line_byte_o,
  output logic        run_last_o,
  output logic        frame_end_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]   command_code_q;
  logic [7:0]   payload_length_q;
  logic         cfg_write;
  logic         q_full;
  logic         q_empty;
  logic         accept;
  logic         job_done;
  job_t         new_job;
  job_t         head_job;
  back_status_t back_status;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_code_q   <= CMD_RESET;
      payload_length_q <= LEN_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_CMD) begin
        command_code_q <= pwdata[7:0];
      end else begin
        payload_length_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CMD: prdata = {24'd0, command_code_q};
      REG_LEN: prdata = {24'd0, payload_length_q};
      default: prdata = 32'd0;
    endcase
  end

  // Front, queue, back
  assign full_o = q_full;
  assign accept = push_i && !q_full;

  efb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .payload_byte_i   (payload_byte_i),
    .command_code_i   (command_code_q),
    .payload_length_i (payload_length_q),
    .job_o            (new_job)
  );

  efb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (new_job),
    .pop_i      (job_done),
    .head_o     (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  efb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (head_job),
    .job_done_o  (job_done),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .line_byte_o (line_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o),
    .status_o    (back_status)
  );

  // Checksum byte always ends its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && frame_end_o) |-> run_last_o)
    else $error("frame_end without run_last");

  // An open escape pair has its escape byte in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.esc_pending |-> (!empty_o && line_byte_o == ESC_BYTE))
    else $error("escape pending without escape byte on output");

  // A raw sync byte is never the last byte of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && line_byte_o == SYNC_BYTE) |-> !run_last_o)
    else $error("unescaped 0xFF ends a request");

  // Mid-escape the back end is always partway through a job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.esc_pending |-> (back_status.busy && !q_empty))
    else $error("escape pending with no active job");

endmodule

>>> rtl/efb_front.sv
// Front end: takes payload bytes, tracks frame position and checksum, builds jobs.
module efb_front
  import efb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] payload_byte_i,
  input  logic [7:0] command_code_i,
  input  logic [7:0] payload_length_i,
  output job_t       job_o
);

  logic [7:0] bytes_done_q, bytes_done_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] sum_base;
  logic [7:0] sum_next;
  logic [7:0] done_next;
  logic       start;
  logic       close;

  // Classify the incoming byte
  always_comb begin
    start     = (bytes_done_q == 8'd0);
    sum_base  = start ? 8'(SYNC_BYTE + command_code_i + payload_length_i) : running_sum_q;
    sum_next  = sum_base + payload_byte_i;
    done_next = bytes_done_q + 8'd1;
    close     = (done_next == payload_length_i);

    job_o.start = start;
    job_o.cmd   = command_code_i;
    job_o.len   = payload_length_i;
    job_o.data  = payload_byte_i;
    job_o.close = close;
    job_o.csum  = 8'd0 - sum_next;

    bytes_done_d  = bytes_done_q;
    running_sum_d = running_sum_q;
    if (accept_i) begin
      bytes_done_d  = close ? 8'd0 : done_next;
      running_sum_d = close ? 8'd0 : sum_next;
    end
  end

  // Frame position and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_done_q  <= 8'd0;
      running_sum_q <= 8'd0;
    end else begin
      bytes_done_q  <= bytes_done_d;
      running_sum_q <= running_sum_d;
    end
  end

endmodule

>>> rtl/efb_queue.sv
// Small job queue between the front and back ends.
module efb_queue
  import efb_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entry_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

>>> rtl/efb_back.sv
// Back end: walks each job byte by byte, escapes, and feeds the output register.
module efb_back
  import efb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         job_valid_i,
  input  job_t         job_i,
  output logic         job_done_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [7:0]   line_byte_o,
  output logic         run_last_o,
  output logic         frame_end_o,
  output back_status_t status_o
);

  slot_e      slot_q, slot_d;
  logic       busy_q, busy_d;
  logic       esc_q, esc_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_end_q;

  slot_e      slot_cur;
  slot_e      slot_nxt;
  logic [7:0] value;
  logic [7:0] emit_byte;
  logic       slot_done;
  logic       job_done;
  logic       fire;

  assign fire = job_valid_i && (!out_valid_q || pop_i);

  // Sequencer: pick the byte, handle escapes, step through the slots
  always_comb begin
    slot_cur = busy_q ? slot_q : (job_i.start ? SLOT_SYNC : SLOT_DATA);

    case (slot_cur)
      SLOT_SYNC: value = SYNC_BYTE;
      SLOT_CMD:  value = job_i.cmd;
      SLOT_LEN:  value = job_i.len;
      SLOT_DATA: value = job_i.data;
      SLOT_CSUM: value = job_i.csum;
      default:   value = job_i.data;
    endcase

    slot_done = 1'b1;
    esc_d     = esc_q;
    if (esc_q) begin
      emit_byte = value - 8'd1;
    end else if (slot_cur != SLOT_SYNC && needs_escape(value)) begin
      emit_byte = ESC_BYTE;
      slot_done = 1'b0;
    end else begin
      emit_byte = value;
    end

    case (slot_cur)
      SLOT_SYNC: slot_nxt = SLOT_CMD;
      SLOT_CMD:  slot_nxt = SLOT_LEN;
      SLOT_LEN:  slot_nxt = SLOT_DATA;
      SLOT_DATA: slot_nxt = SLOT_CSUM;
      default:   slot_nxt = SLOT_CSUM;
    endcase

    job_done = slot_done &&
               ((slot_cur == SLOT_CSUM) || (slot_cur == SLOT_DATA && !job_i.close));

    slot_d = slot_q;
    busy_d = busy_q;
    if (fire) begin
      esc_d = !slot_done;
      if (!slot_done) begin
        slot_d = slot_cur;
        busy_d = 1'b1;
      end else if (job_done) begin
        busy_d = 1'b0;
      end else begin
        slot_d = slot_nxt;
        busy_d = 1'b1;
      end
    end

    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= SLOT_SYNC;
      busy_q      <= 1'b0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      busy_q      <= busy_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= emit_byte;
      out_last_q <= job_done;
      out_end_q  <= job_done && (slot_cur == SLOT_CSUM);
    end
  end

  assign job_done_o           = fire && job_done;
  assign empty_o              = !out_valid_q;
  assign line_byte_o          = out_byte_q;
  assign run_last_o           = out_last_q;
  assign frame_end_o          = out_end_q;
  assign status_o.esc_pending = esc_q;
  assign status_o.busy        = busy_q;

endmodule
